FILE: design/srbrm_pkg.sv
package srbrm_pkg;

    localparam int NUM_BUFS       = 32;
    localparam int RING_DEPTH     = 32;
    localparam int DELIVERY_DEPTH = 16;
    localparam int MAX_CONSUMERS  = 8;
    localparam int MAX_RESULTS    = 48;
    localparam int START_REFS     = 2;

    localparam int ID_W   = 5;
    localparam int SEQ_W  = 32;
    localparam int APP_W  = 3;
    localparam int QUO_W  = 6;
    localparam int CNT_W  = 4;
    localparam int RA_W   = $clog2(RING_DEPTH);
    localparam int SLOT_W = $clog2(DELIVERY_DEPTH);
    localparam int RES_W  = $clog2(MAX_RESULTS);

    localparam logic [2:0] REQ_START    = 3'd0;
    localparam logic [2:0] REQ_END      = 3'd1;
    localparam logic [2:0] REQ_ATTACH   = 3'd2;
    localparam logic [2:0] REQ_DETACH   = 3'd3;
    localparam logic [2:0] REQ_RETURN   = 3'd4;
    localparam logic [2:0] REQ_CONSUMED = 3'd5;

    localparam logic [1:0] RES_DONE    = 2'd0;
    localparam logic [1:0] RES_RELEASE = 2'd1;
    localparam logic [1:0] RES_POST    = 2'd2;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [ID_W-1:0]  buf_id;
        logic [SEQ_W-1:0] buf_seq;
        logic             sentinel;
        logic [APP_W-1:0] app_index;
        logic [QUO_W-1:0] app_quota;
        logic [SEQ_W-1:0] ring_removed;
    } req_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [ID_W-1:0]   buf_id;
        logic [SEQ_W-1:0]  buf_seq;
        logic              sentinel;
        logic [APP_W-1:0]  app;
        logic [SLOT_W-1:0] ring_slot;
        logic              ret_value;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [ID_W-1:0]  id;
        logic             sent;
    } ring_entry_t;

    typedef struct packed {
        logic             wen;
        logic             ren;
        logic [RA_W-1:0]  addr;
        ring_entry_t      wdata;
    } ring_cmd_t;

    // Wrap-safe sequence compare: a is older than b.
    function automatic logic seq_lt(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d[SEQ_W-1];
    endfunction

    function automatic logic id_ok(logic [ID_W-1:0] id);
        return {1'b0, id} < (ID_W+1)'(NUM_BUFS);
    endfunction

endpackage

FILE: design/shared_rx_buffer_refcount_manager.sv
// Sequencing: every request ends in a done item. A start visits each live consumer and may post
// to it, a return may post, and a detach walks every buffer id; a start, an end or a detach may
// also drop skipped buffers, and a start or a return that posts drops aged ones. Output
// back-pressure stalls the states that emit result items.
// Throughput: one request at a time; the sequencer and the single buffer-ring port set the pace.
// Reset: rst_n is asynchronous, active low; it clears counters, reference counts and slots.
module shared_rx_buffer_refcount_manager (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // buf_id[4:0], buf_seq[36:5], sentinel[37], app_index[40:38], app_quota[46:41],
    // ring_removed[78:47], zero pad[79]
    input  logic [79:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_buf_id[4:0], out_buf_seq[36:5], out_sentinel[37], out_app[40:38],
    // ring_slot[44:41], ret_value[45], zero pad[47:46]
    output logic [47:0] m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    srbrm_pkg::req_t        req;
    srbrm_pkg::result_t     emit_res;
    srbrm_pkg::result_t     out_reg;
    srbrm_pkg::ring_cmd_t   ring_cmd;
    srbrm_pkg::ring_entry_t ring_rdata;
    logic                   emit;
    logic                   out_free;
    logic                   out_valid_reg;

    // Unpack the incoming item into the request record.
    assign req.req_type     = s_axis_tuser;
    assign req.buf_id       = s_axis_tdata[4:0];
    assign req.buf_seq      = s_axis_tdata[36:5];
    assign req.sentinel     = s_axis_tdata[37];
    assign req.app_index    = s_axis_tdata[40:38];
    assign req.app_quota    = s_axis_tdata[46:41];
    assign req.ring_removed = s_axis_tdata[78:47];

    srbrm_ring_mem u_ring (
        .clk   (clk),
        .cmd   (ring_cmd),
        .rdata (ring_rdata)
    );

    srbrm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_req     (req),
        .out_free   (out_free),
        .emit       (emit),
        .emit_res   (emit_res),
        .ring_cmd   (ring_cmd),
        .ring_rdata (ring_rdata)
    );

    // The output register frees up in the same cycle its item is taken, so the sequencer
    // can produce one result item per cycle while the sink keeps up.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= emit_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.result_kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {2'b00, out_reg.ret_value, out_reg.ring_slot, out_reg.app,
                            out_reg.sentinel, out_reg.buf_seq, out_reg.buf_id};

endmodule

FILE: design/srbrm_ring_mem.sv
module srbrm_ring_mem (
    input  logic                   clk,
    input  srbrm_pkg::ring_cmd_t   cmd,
    output srbrm_pkg::ring_entry_t rdata
);

    srbrm_pkg::ring_entry_t mem [srbrm_pkg::RING_DEPTH];
    srbrm_pkg::ring_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wen)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
        if (cmd.ren)
        begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/srbrm_ctrl.sv
module srbrm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  srbrm_pkg::req_t        in_req,
    input  logic                   out_free,
    output logic                   emit,
    output srbrm_pkg::result_t     emit_res,
    output srbrm_pkg::ring_cmd_t   ring_cmd,
    input  srbrm_pkg::ring_entry_t ring_rdata
);

    localparam int SW = srbrm_pkg::SEQ_W;
    localparam int CW = $clog2(srbrm_pkg::MAX_CONSUMERS);
    localparam logic [CW-1:0] LAST_C = CW'(srbrm_pkg::MAX_CONSUMERS - 1);
    localparam logic [srbrm_pkg::ID_W-1:0] LAST_ID = srbrm_pkg::ID_W'(srbrm_pkg::NUM_BUFS - 1);

    typedef enum logic [21:0] {
        S_IDLE      = 22'h000001,
        S_ST_CHK    = 22'h000002,
        S_ST_WR     = 22'h000004,
        S_ST_LOOP   = 22'h000008,
        S_PO_CHK    = 22'h000010,
        S_PO_DO     = 22'h000020,
        S_NM        = 22'h000040,
        S_UO        = 22'h000080,
        S_ADV_CHK   = 22'h000100,
        S_ADV_DROP  = 22'h000200,
        S_SKIP_CHK  = 22'h000400,
        S_SKIP_DROP = 22'h000800,
        S_END_CHK   = 22'h001000,
        S_END_DEC   = 22'h002000,
        S_ATT       = 22'h004000,
        S_DET_START = 22'h008000,
        S_DET_WALK  = 22'h010000,
        S_DET_Q     = 22'h020000,
        S_DET_SKIP  = 22'h040000,
        S_RET       = 22'h080000,
        S_CONS      = 22'h100000,
        S_DONE      = 22'h200000
    } state_t;

    typedef struct packed {
        logic                        live;
        logic [SW-1:0]               nseq;
        logic [srbrm_pkg::QUO_W-1:0] owned;
        logic [srbrm_pkg::QUO_W-1:0] quota;
        logic [SW-1:0]               dadd;
        logic [SW-1:0]               drem;
    } cons_t;

    typedef struct packed {
        logic [SW-1:0] too_many;
        logic [SW-1:0] no_space;
        logic [SW-1:0] skipped;
    } stat_t;

    state_t state_reg, state_next;
    srbrm_pkg::req_t req_reg, req_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [srbrm_pkg::ID_W-1:0] walk_reg, walk_next;
    logic [SW-1:0] added_reg, added_next;
    logic [SW-1:0] removed_reg, removed_next;
    logic [SW-1:0] oldest_reg, oldest_next;
    logic [SW-1:0] held_reg, held_next;
    logic [SW-1:0] qsum_reg, qsum_next;
    logic [SW-1:0] m_reg, m_next;
    logic posted_reg, posted_next;
    logic ret_reg, ret_next;
    logic [srbrm_pkg::RES_W-1:0] resn_reg, resn_next;

    logic [srbrm_pkg::CNT_W-1:0] ref_reg [srbrm_pkg::NUM_BUFS];
    cons_t cons_reg [srbrm_pkg::MAX_CONSUMERS];
    stat_t stat_reg [srbrm_pkg::MAX_CONSUMERS];
    logic [srbrm_pkg::NUM_BUFS-1:0] owns_reg [srbrm_pkg::MAX_CONSUMERS];

    cons_t cons_c, cons_next;
    stat_t stat_c, stat_next;
    logic [srbrm_pkg::NUM_BUFS-1:0] owns_c, owns_next;
    logic [srbrm_pkg::ID_W-1:0] ref_addr;
    logic [srbrm_pkg::CNT_W-1:0] ref_rd, ref_dec, ref_inc, ref_next;
    logic dz, step, lag, slot_ok, emit_v;
    logic [SW-1:0] nm_seq, nm_m, pseq;
    srbrm_pkg::result_t res;

    assign cons_c  = cons_reg[cur_reg];
    assign stat_c  = stat_reg[cur_reg];
    assign owns_c  = owns_reg[cur_reg];
    assign lag     = srbrm_pkg::seq_lt(cons_c.nseq, oldest_reg);
    assign nm_seq  = lag ? oldest_reg : cons_c.nseq;
    assign nm_m    = srbrm_pkg::seq_lt(nm_seq, m_reg) ? nm_seq : m_reg;
    assign pseq    = lag ? oldest_reg : cons_c.nseq;
    assign slot_ok = {1'b0, req_reg.app_index} < (srbrm_pkg::APP_W+1)'(srbrm_pkg::MAX_CONSUMERS);

    always_comb
    begin
        unique case (state_reg)
            S_SKIP_DROP, S_ADV_DROP, S_PO_DO: ref_addr = ring_rdata.id;
            S_DET_WALK:                       ref_addr = walk_reg;
            default:                          ref_addr = req_reg.buf_id;
        endcase
    end

    assign ref_rd  = ref_reg[ref_addr];
    assign ref_dec = ref_rd - 1'b1;
    assign ref_inc = ref_rd + 1'b1;
    assign dz      = srbrm_pkg::id_ok(ref_addr) && (ref_dec == '0);

    // States that may produce a result wait for room in the output register.
    assign step = !(state_reg == S_PO_DO || state_reg == S_SKIP_DROP ||
                    state_reg == S_ADV_DROP || state_reg == S_DET_WALK ||
                    state_reg == S_RET || state_reg == S_DONE) || out_free;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        cur_next     = cur_reg;
        walk_next    = walk_reg;
        added_next   = added_reg;
        removed_next = removed_reg;
        oldest_next  = oldest_reg;
        held_next    = held_reg;
        qsum_next    = qsum_reg;
        m_next       = m_reg;
        posted_next  = posted_reg;
        ret_next     = ret_reg;
        resn_next    = resn_reg;
        cons_next    = cons_c;
        stat_next    = stat_c;
        owns_next    = owns_c;
        ref_next     = ref_rd;
        ring_cmd     = '0;
        emit_v       = 1'b0;
        res          = '0;

        if (step)
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_next  = in_req;
                        cur_next  = in_req.app_index[CW-1:0];
                        resn_next = '0;
                        ret_next  = 1'b0;
                        unique case (in_req.req_type)
                            srbrm_pkg::REQ_START:    state_next = S_ST_CHK;
                            srbrm_pkg::REQ_END:      state_next = S_END_CHK;
                            srbrm_pkg::REQ_ATTACH:   state_next = S_ATT;
                            srbrm_pkg::REQ_DETACH:   state_next = S_DET_START;
                            srbrm_pkg::REQ_RETURN:   state_next = S_RET;
                            srbrm_pkg::REQ_CONSUMED: state_next = S_CONS;
                            default:                 state_next = S_DONE;
                        endcase
                    end
                end
                S_ST_CHK:
                begin
                    if (!srbrm_pkg::id_ok(req_reg.buf_id) ||
                        (added_reg - (srbrm_pkg::seq_lt(oldest_reg, removed_reg) ?
                         oldest_reg : removed_reg)) >= SW'(srbrm_pkg::RING_DEPTH))
                    begin
                        state_next = S_DONE;
                    end
                    else if (held_reg >= qsum_reg)
                    begin
                        state_next = S_SKIP_CHK;
                    end
                    else
                    begin
                        state_next = S_ST_WR;
                    end
                end
                S_ST_WR:
                begin
                    ref_next             = srbrm_pkg::CNT_W'(srbrm_pkg::START_REFS);
                    ring_cmd.wen         = 1'b1;
                    ring_cmd.addr        = added_reg[srbrm_pkg::RA_W-1:0];
                    ring_cmd.wdata.seq   = req_reg.buf_seq;
                    ring_cmd.wdata.id    = req_reg.buf_id;
                    ring_cmd.wdata.sent  = req_reg.sentinel;
                    added_next           = added_reg + 1'b1;
                    held_next            = held_reg + 1'b1;
                    m_next               = added_reg + 1'b1;
                    posted_next          = 1'b0;
                    ret_next             = 1'b1;
                    cur_next             = '0;
                    state_next           = S_ST_LOOP;
                end
                S_ST_LOOP:
                begin
                    if (cons_c.live)
                    begin
                        state_next = S_PO_CHK;
                    end
                    else if (cur_reg == LAST_C)
                    begin
                        state_next = posted_reg ? S_ADV_CHK : S_DONE;
                    end
                    else
                    begin
                        cur_next = cur_reg + 1'b1;
                    end
                end
                S_PO_CHK:
                begin
                    state_next = (req_reg.req_type == srbrm_pkg::REQ_START) ? S_NM : S_DONE;
                    if (!cons_c.live || cons_c.nseq == added_reg)
                    begin
                    end
                    else if (cons_c.owned >= cons_c.quota)
                    begin
                        stat_next.too_many = stat_c.too_many + 1'b1;
                    end
                    else if ((cons_c.dadd - cons_c.drem) >= SW'(srbrm_pkg::DELIVERY_DEPTH))
                    begin
                        stat_next.no_space = stat_c.no_space + 1'b1;
                    end
                    else
                    begin
                        if (lag)
                        begin
                            stat_next.skipped = stat_c.skipped + (oldest_reg - cons_c.nseq);
                        end
                        cons_next.nseq = pseq + 1'b1;
                        ring_cmd.ren   = 1'b1;
                        ring_cmd.addr  = pseq[srbrm_pkg::RA_W-1:0];
                        state_next     = S_PO_DO;
                    end
                end
                S_PO_DO:
                begin
                    if (srbrm_pkg::id_ok(ring_rdata.id))
                    begin
                        ref_next                 = ref_inc;
                        owns_next[ring_rdata.id] = 1'b1;
                    end
                    cons_next.owned = cons_c.owned + 1'b1;
                    cons_next.dadd  = cons_c.dadd + 1'b1;
                    emit_v          = 1'b1;
                    res.result_kind = srbrm_pkg::RES_POST;
                    res.buf_id      = ring_rdata.id;
                    res.buf_seq     = ring_rdata.seq;
                    res.sentinel    = ring_rdata.sent;
                    res.app         = srbrm_pkg::APP_W'(cur_reg);
                    res.ring_slot   = cons_c.dadd[srbrm_pkg::SLOT_W-1:0];
                    posted_next     = 1'b1;
                    if (req_reg.req_type == srbrm_pkg::REQ_START)
                    begin
                        state_next = S_NM;
                    end
                    else
                    begin
                        cur_next   = '0;
                        m_next     = added_reg;
                        state_next = S_UO;
                    end
                end
                S_NM, S_UO:
                begin
                    if (cons_c.live)
                    begin
                        if (lag)
                        begin
                            cons_next.nseq    = oldest_reg;
                            stat_next.skipped = stat_c.skipped + (oldest_reg - cons_c.nseq);
                        end
                        m_next = nm_m;
                    end
                    if (cur_reg == LAST_C)
                    begin
                        if (state_reg == S_UO)
                        begin
                            state_next = S_ADV_CHK;
                        end
                        else
                        begin
                            state_next = posted_reg ? S_ADV_CHK : S_DONE;
                        end
                    end
                    else
                    begin
                        cur_next   = cur_reg + 1'b1;
                        state_next = (state_reg == S_UO) ? S_UO : S_ST_LOOP;
                    end
                end
                S_ADV_CHK:
                begin
                    if (srbrm_pkg::seq_lt(m_reg, oldest_reg) || m_reg == oldest_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ring_cmd.ren  = 1'b1;
                        ring_cmd.addr = oldest_reg[srbrm_pkg::RA_W-1:0];
                        state_next    = S_ADV_DROP;
                    end
                end
                S_SKIP_CHK:
                begin
                    if (!srbrm_pkg::seq_lt(oldest_reg, removed_reg))
                    begin
                        priority case (req_reg.req_type)
                            srbrm_pkg::REQ_START: state_next = S_ST_WR;
                            srbrm_pkg::REQ_END:   state_next = S_END_DEC;
                            default:              state_next = S_DET_SKIP;
                        endcase
                    end
                    else
                    begin
                        ring_cmd.ren  = 1'b1;
                        ring_cmd.addr = oldest_reg[srbrm_pkg::RA_W-1:0];
                        state_next    = S_SKIP_DROP;
                    end
                end
                S_ADV_DROP, S_SKIP_DROP:
                begin
                    oldest_next = oldest_reg + 1'b1;
                    if (srbrm_pkg::id_ok(ref_addr))
                    begin
                        ref_next = ref_dec;
                    end
                    if (dz)
                    begin
                        emit_v          = 1'b1;
                        res.result_kind = srbrm_pkg::RES_RELEASE;
                        res.buf_id      = ref_addr;
                        held_next       = held_reg - 1'b1;
                    end
                    if (state_reg == S_ADV_DROP)
                    begin
                        state_next = S_ADV_CHK;
                    end
                    else if (!dz)
                    begin
                        state_next = S_SKIP_CHK;
                    end
                    else
                    begin
                        priority case (req_reg.req_type)
                            srbrm_pkg::REQ_START: state_next = S_ST_WR;
                            srbrm_pkg::REQ_END:   state_next = S_END_DEC;
                            default:              state_next = S_DET_SKIP;
                        endcase
                    end
                end
                S_END_CHK:
                begin
                    if (!srbrm_pkg::id_ok(req_reg.buf_id) || removed_reg == added_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        removed_next = removed_reg + 1'b1;
                        state_next   = (held_reg > qsum_reg) ? S_SKIP_CHK : S_END_DEC;
                    end
                end
                S_END_DEC:
                begin
                    ref_next = ref_dec;
                    if (ref_dec == '0)
                    begin
                        held_next = held_reg - 1'b1;
                        ret_next  = 1'b1;
                    end
                    state_next = S_DONE;
                end
                S_ATT:
                begin
                    if (slot_ok && !cons_c.live)
                    begin
                        cons_next.live  = 1'b1;
                        cons_next.nseq  = added_reg;
                        cons_next.owned = '0;
                        cons_next.quota = req_reg.app_quota;
                        cons_next.dadd  = '0;
                        cons_next.drem  = '0;
                        stat_next       = '0;
                        owns_next       = '0;
                        qsum_next       = qsum_reg + SW'(req_reg.app_quota);
                    end
                    state_next = S_DONE;
                end
                S_DET_START:
                begin
                    if (slot_ok && cons_c.live)
                    begin
                        cons_next.live = 1'b0;
                        walk_next      = '0;
                        state_next     = S_DET_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                S_DET_WALK:
                begin
                    if (owns_c[walk_reg])
                    begin
                        owns_next[walk_reg] = 1'b0;
                        cons_next.owned     = cons_c.owned - 1'b1;
                        ref_next            = ref_dec;
                        if (dz)
                        begin
                            emit_v          = 1'b1;
                            res.result_kind = srbrm_pkg::RES_RELEASE;
                            res.buf_id      = walk_reg;
                            held_next       = held_reg - 1'b1;
                        end
                    end
                    if (walk_reg == LAST_ID)
                    begin
                        state_next = S_DET_Q;
                    end
                    else
                    begin
                        walk_next = walk_reg + 1'b1;
                    end
                end
                S_DET_Q:
                begin
                    qsum_next  = qsum_reg - SW'(cons_c.quota);
                    state_next = S_DET_SKIP;
                end
                S_DET_SKIP:
                begin
                    if (srbrm_pkg::seq_lt(oldest_reg, removed_reg) && held_reg > qsum_reg)
                    begin
                        state_next = S_SKIP_CHK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                S_RET:
                begin
                    if (slot_ok && cons_c.live && srbrm_pkg::id_ok(req_reg.buf_id) &&
                        owns_c[req_reg.buf_id])
                    begin
                        owns_next[req_reg.buf_id] = 1'b0;
                        cons_next.owned           = cons_c.owned - 1'b1;
                        ref_next                  = ref_dec;
                        if (dz)
                        begin
                            emit_v          = 1'b1;
                            res.result_kind = srbrm_pkg::RES_RELEASE;
                            res.buf_id      = req_reg.buf_id;
                            held_next       = held_reg - 1'b1;
                        end
                        state_next = S_PO_CHK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                S_CONS:
                begin
                    if (slot_ok && cons_c.live)
                    begin
                        cons_next.drem = req_reg.ring_removed;
                    end
                    state_next = S_DONE;
                end
                S_DONE:
                begin
                    emit_v          = 1'b1;
                    res.result_kind = srbrm_pkg::RES_DONE;
                    res.ret_value   = ret_reg;
                    res.last        = 1'b1;
                    state_next      = S_IDLE;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end

        // Results past the cap are dropped, but their state effects stand.
        emit = emit_v && (res.last || resn_reg < srbrm_pkg::RES_W'(srbrm_pkg::MAX_RESULTS - 1));
        if (emit && !res.last)
        begin
            resn_next = resn_reg + 1'b1;
        end
    end

    assign emit_res = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            req_reg     <= '0;
            cur_reg     <= '0;
            walk_reg    <= '0;
            added_reg   <= '0;
            removed_reg <= '0;
            oldest_reg  <= '0;
            held_reg    <= '0;
            qsum_reg    <= '0;
            m_reg       <= '0;
            posted_reg  <= 1'b0;
            ret_reg     <= 1'b0;
            resn_reg    <= '0;
            for (int i = 0; i < srbrm_pkg::NUM_BUFS; i++)
            begin
                ref_reg[i] <= '0;
            end
            for (int j = 0; j < srbrm_pkg::MAX_CONSUMERS; j++)
            begin
                cons_reg[j] <= '0;
                stat_reg[j] <= '0;
                owns_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            req_reg     <= req_next;
            cur_reg     <= cur_next;
            walk_reg    <= walk_next;
            added_reg   <= added_next;
            removed_reg <= removed_next;
            oldest_reg  <= oldest_next;
            held_reg    <= held_next;
            qsum_reg    <= qsum_next;
            m_reg       <= m_next;
            posted_reg  <= posted_next;
            ret_reg     <= ret_next;
            resn_reg    <= resn_next;
            ref_reg[ref_addr]  <= ref_next;
            cons_reg[cur_reg]  <= cons_next;
            stat_reg[cur_reg]  <= stat_next;
            owns_reg[cur_reg]  <= owns_next;
        end
    end

endmodule

FILE: bench/tb.sv
module tb;

    // Clock, reset and the two stream groups of the block.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    shared_rx_buffer_refcount_manager DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // Requests waiting for the driver, and results the block still owes us.
    srbrm_pkg::req_t    pending_reqs[$];
    srbrm_pkg::result_t owed_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_go = 1'b0;
    bit hold_started = 1'b0;
    int hold_left = 0;
    bit s_taken = 1'b0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // Shadow copy of the manager's state. Statistics counters are never visible
    // at the ports, so they are not tracked here.
    logic [srbrm_pkg::SEQ_W-1:0] sh_ring_seq[srbrm_pkg::RING_DEPTH];
    logic [srbrm_pkg::ID_W-1:0]  sh_ring_id[srbrm_pkg::RING_DEPTH];
    logic                        sh_ring_sent[srbrm_pkg::RING_DEPTH];
    logic [31:0]                 sh_added;
    logic [31:0]                 sh_removed;
    logic [31:0]                 sh_oldest;
    logic [srbrm_pkg::CNT_W-1:0] sh_refs[srbrm_pkg::NUM_BUFS];
    logic [31:0]                 sh_held;
    logic [31:0]                 sh_quota_sum;
    logic                        sh_live[srbrm_pkg::MAX_CONSUMERS];
    logic [31:0]                 sh_next[srbrm_pkg::MAX_CONSUMERS];
    logic [5:0]                  sh_owned[srbrm_pkg::MAX_CONSUMERS];
    logic [5:0]                  sh_quota[srbrm_pkg::MAX_CONSUMERS];
    logic [31:0]                 sh_owns[srbrm_pkg::MAX_CONSUMERS];
    logic [31:0]                 sh_dadd[srbrm_pkg::MAX_CONSUMERS];
    logic [31:0]                 sh_drem[srbrm_pkg::MAX_CONSUMERS];
    int                          results_this_req;

    // Wrap-safe "a is older than b" on 32-bit sequence numbers.
    function automatic bit older(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    // Queue one result. Release and post results past the reporting limit are
    // dropped, but the done result always goes out.
    function automatic void owe(logic [1:0] kind, logic [4:0] id, logic [31:0] seq,
                                logic sent, logic [2:0] app, logic [3:0] slot,
                                logic ret, logic fin);
        srbrm_pkg::result_t r;
        if (!fin && results_this_req >= srbrm_pkg::MAX_RESULTS - 1)
            return;
        r.result_kind = kind;
        r.buf_id      = id;
        r.buf_seq     = seq;
        r.sentinel    = sent;
        r.app         = app;
        r.ring_slot   = slot;
        r.ret_value   = ret;
        r.last        = fin;
        owed_results.push_back(r);
        results_this_req++;
    endfunction

    function automatic bit unref(logic [4:0] id);
        sh_refs[id] = sh_refs[id] - 1'b1;
        if (sh_refs[id] == 0)
        begin
            owe(srbrm_pkg::RES_RELEASE, id, '0, 1'b0, '0, '0, 1'b0, 1'b0);
            sh_held = sh_held - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Hand the next buffer to consumer a if its quota and ring space allow it.
    function automatic bit deliver(int a);
        logic [31:0] s;
        logic [4:0]  idx;
        if (!sh_live[a] || sh_next[a] == sh_added)
            return 1'b0;
        if (sh_owned[a] >= sh_quota[a])
            return 1'b0;
        if (sh_dadd[a] - sh_drem[a] >= srbrm_pkg::DELIVERY_DEPTH)
            return 1'b0;
        s = older(sh_next[a], sh_oldest) ? sh_oldest : sh_next[a];
        idx = s[4:0];
        sh_next[a] = s + 1;
        sh_refs[sh_ring_id[idx]] = sh_refs[sh_ring_id[idx]] + 1'b1;
        sh_owns[a][sh_ring_id[idx]] = 1'b1;
        sh_owned[a] = sh_owned[a] + 1'b1;
        owe(srbrm_pkg::RES_POST, sh_ring_id[idx], sh_ring_seq[idx], sh_ring_sent[idx], a[2:0],
            sh_dadd[a][3:0], 1'b0, 1'b0);
        sh_dadd[a] = sh_dadd[a] + 1;
        return 1'b1;
    endfunction

    // A consumer that lags behind the oldest held buffer is pulled forward.
    function automatic logic [31:0] lowest_read(int a, logic [31:0] m);
        if (older(sh_next[a], sh_oldest))
            sh_next[a] = sh_oldest;
        return older(sh_next[a], m) ? sh_next[a] : m;
    endfunction

    function automatic void age_to(logic [31:0] target);
        logic [4:0] id;
        if (older(target, sh_oldest))
            return;
        while (sh_oldest != target)
        begin
            id = sh_ring_id[sh_oldest[4:0]];
            sh_oldest = sh_oldest + 1;
            void'(unref(id));
        end
    endfunction

    function automatic void refresh_oldest();
        logic [31:0] m;
        m = sh_added;
        for (int a = 0; a < srbrm_pkg::MAX_CONSUMERS; a++)
            if (sh_live[a])
                m = lowest_read(a, m);
        age_to(m);
    endfunction

    // Drop the oldest ended buffers until one of them is actually freed.
    function automatic void skip_oldest();
        logic [4:0] id;
        forever
        begin
            if (!older(sh_oldest, sh_removed))
                return;
            id = sh_ring_id[sh_oldest[4:0]];
            sh_oldest = sh_oldest + 1;
            if (unref(id))
                return;
        end
    endfunction

    function automatic logic buffer_start(logic [4:0] id, logic [31:0] seq, logic sent);
        logic [31:0] lo;
        logic [31:0] m;
        bit          posted;
        lo = older(sh_oldest, sh_removed) ? sh_oldest : sh_removed;
        if (sh_added - lo >= srbrm_pkg::RING_DEPTH)
            return 1'b0;
        if (sh_held >= sh_quota_sum)
            skip_oldest();
        sh_refs[id] = srbrm_pkg::CNT_W'(srbrm_pkg::START_REFS);
        sh_ring_seq[sh_added[4:0]]  = seq;
        sh_ring_id[sh_added[4:0]]   = id;
        sh_ring_sent[sh_added[4:0]] = sent;
        sh_added = sh_added + 1;
        sh_held = sh_held + 1;
        m = sh_added;
        posted = 1'b0;
        for (int a = 0; a < srbrm_pkg::MAX_CONSUMERS; a++)
        begin
            if (sh_live[a])
            begin
                if (deliver(a))
                    posted = 1'b1;
                m = lowest_read(a, m);
            end
        end
        if (posted)
            age_to(m);
        return 1'b1;
    endfunction

    function automatic logic buffer_end(logic [4:0] id);
        if (sh_removed == sh_added)
            return 1'b0;
        sh_removed = sh_removed + 1;
        if (sh_held > sh_quota_sum)
            skip_oldest();
        sh_refs[id] = sh_refs[id] - 1'b1;
        if (sh_refs[id] == 0)
        begin
            sh_held = sh_held - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void consumer_detach(int a);
        sh_live[a] = 1'b0;
        for (int id = 0; id < srbrm_pkg::NUM_BUFS; id++)
        begin
            if (sh_owns[a][id])
            begin
                sh_owns[a][id] = 1'b0;
                sh_owned[a] = sh_owned[a] - 1'b1;
                void'(unref(id[4:0]));
            end
        end
        sh_quota_sum = sh_quota_sum - sh_quota[a];
        while (older(sh_oldest, sh_removed) && sh_held > sh_quota_sum)
            skip_oldest();
    endfunction

    // Advance the shadow state by one request and queue every result it owes.
    function automatic void predict_request(srbrm_pkg::req_t r);
        logic ret;
        int   a;
        ret = 1'b0;
        a = r.app_index;
        results_this_req = 0;
        case (r.req_type)
            srbrm_pkg::REQ_START:
                ret = buffer_start(r.buf_id, r.buf_seq, r.sentinel);
            srbrm_pkg::REQ_END:
                ret = buffer_end(r.buf_id);
            srbrm_pkg::REQ_ATTACH:
                if (!sh_live[a])
                begin
                    sh_live[a] = 1'b1;
                    sh_next[a] = sh_added;
                    sh_owned[a] = '0;
                    sh_quota[a] = r.app_quota;
                    sh_owns[a] = '0;
                    sh_dadd[a] = '0;
                    sh_drem[a] = '0;
                    sh_quota_sum = sh_quota_sum + r.app_quota;
                end
            srbrm_pkg::REQ_DETACH:
                if (sh_live[a])
                    consumer_detach(a);
            srbrm_pkg::REQ_RETURN:
                if (sh_live[a] && sh_owns[a][r.buf_id])
                begin
                    sh_owns[a][r.buf_id] = 1'b0;
                    sh_owned[a] = sh_owned[a] - 1'b1;
                    void'(unref(r.buf_id));
                    if (deliver(a))
                        refresh_oldest();
                end
            srbrm_pkg::REQ_CONSUMED:
                if (sh_live[a])
                    sh_drem[a] = r.ring_removed;
            default:
                ;
        endcase
        owe(srbrm_pkg::RES_DONE, '0, '0, 1'b0, '0, '0, ret, 1'b1);
    endfunction

    // Requests are predicted in issue order, which is also acceptance order,
    // so the shadow state always matches the block after the queue drains.
    task automatic issue(logic [2:0] kind, logic [4:0] id, logic [31:0] seq, logic sent,
                         logic [2:0] app, logic [5:0] quota, logic [31:0] rrem);
        srbrm_pkg::req_t r;
        r.req_type     = kind;
        r.buf_id       = id;
        r.buf_seq      = seq;
        r.sentinel     = sent;
        r.app_index    = app;
        r.app_quota    = quota;
        r.ring_removed = rrem;
        predict_request(r);
        pending_reqs.push_back(r);
    endtask

    // One random request. Most are well-formed against the current shadow
    // state; a few are noise that the block should ignore or refuse.
    task automatic issue_random();
        int          pick;
        int          a;
        int          owners[$];
        int          held_ids[$];
        logic [31:0] rrem;
        pick = $urandom_range(0, 99);
        a = $urandom_range(0, srbrm_pkg::MAX_CONSUMERS - 1);
        if (pick < 36)
            issue(srbrm_pkg::REQ_START, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
        else if (pick < 56)
        begin
            if (sh_removed != sh_added && $urandom_range(0, 9) != 0)
                issue(srbrm_pkg::REQ_END, sh_ring_id[sh_removed[4:0]], $urandom, $urandom,
                      $urandom, $urandom, $urandom);
            else
                issue(srbrm_pkg::REQ_END, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
        end
        else if (pick < 76)
        begin
            for (int k = 0; k < srbrm_pkg::MAX_CONSUMERS; k++)
                if (sh_live[k] && sh_owns[k] != 0)
                    owners.push_back(k);
            if (owners.size() != 0 && $urandom_range(0, 9) != 0)
            begin
                a = owners[$urandom_range(0, owners.size() - 1)];
                for (int id = 0; id < srbrm_pkg::NUM_BUFS; id++)
                    if (sh_owns[a][id])
                        held_ids.push_back(id);
                issue(srbrm_pkg::REQ_RETURN, held_ids[$urandom_range(0, held_ids.size() - 1)],
                      $urandom, $urandom, a, $urandom, $urandom);
            end
            else
                issue(srbrm_pkg::REQ_RETURN, $urandom, $urandom, $urandom, a, $urandom,
                      $urandom);
        end
        else if (pick < 88)
        begin
            // Usually report the whole delivery ring as drained, sometimes only
            // part of it, and rarely a wild counter value.
            case ($urandom_range(0, 9))
                0:       rrem = $urandom;
                1, 2:    rrem = sh_dadd[a] - $urandom_range(1, 3);
                default: rrem = sh_dadd[a];
            endcase
            issue(srbrm_pkg::REQ_CONSUMED, $urandom, $urandom, $urandom, a, $urandom, rrem);
        end
        else if (pick < 95)
            issue(srbrm_pkg::REQ_ATTACH, $urandom, $urandom, $urandom, a,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 6),
                  $urandom);
        else
            issue(srbrm_pkg::REQ_DETACH, $urandom, $urandom, $urandom, a, $urandom, $urandom);
    endtask

    // Wait until every owed result has come back and the block has settled.
    task automatic drain();
        while (pending_reqs.size() != 0 || s_axis_tvalid || owed_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Driver: a new request goes out at the falling edge once the previous one
    // has been taken, unless the sender chooses to idle this cycle.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_taken)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_reqs[0].req_type;
                s_axis_tdata  <= {1'b0, pending_reqs[0].ring_removed, pending_reqs[0].app_quota,
                                  pending_reqs[0].app_index, pending_reqs[0].sentinel,
                                  pending_reqs[0].buf_seq, pending_reqs[0].buf_id};
                void'(pending_reqs.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver side: random back-pressure plus one long hold-off that lets the
    // block back up into its input.
    always @(negedge clk)
    begin
        if (hold_go && !hold_started)
        begin
            hold_started <= 1'b1;
            hold_left <= 700;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: each result is checked against the oldest owed result.
    always @(posedge clk)
    begin
        s_taken <= s_axis_tvalid && s_axis_tready;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: kind %0d data %h last %0d",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                if (m_axis_tuser !== owed_results[0].result_kind
                    || m_axis_tdata[4:0] !== owed_results[0].buf_id
                    || m_axis_tdata[36:5] !== owed_results[0].buf_seq
                    || m_axis_tdata[37] !== owed_results[0].sentinel
                    || m_axis_tdata[40:38] !== owed_results[0].app
                    || m_axis_tdata[44:41] !== owed_results[0].ring_slot
                    || m_axis_tdata[45] !== owed_results[0].ret_value
                    || m_axis_tdata[47:46] !== 2'b00
                    || m_axis_tlast !== owed_results[0].last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected kind %0d id %0d seq %h sent %0d app %0d",
                                 owed_results[0].result_kind, owed_results[0].buf_id,
                                 owed_results[0].buf_seq, owed_results[0].sentinel,
                                 owed_results[0].app,
                                 " slot %0d ret %0d last %0d; got kind %0d data %h last %0d",
                                 owed_results[0].ring_slot, owed_results[0].ret_value,
                                 owed_results[0].last, m_axis_tuser, m_axis_tdata,
                                 m_axis_tlast);
                end
                void'(owed_results.pop_front());
            end
        end
    end

    // Watchdog: a long stretch with no item moving on either side is a hang.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000)
        begin
            $display("shared_rx_buffer_refcount_manager verification failed");
            $finish;
        end
    end

    initial
    begin
        sh_added = '0;
        sh_removed = '0;
        sh_oldest = '0;
        sh_held = '0;
        sh_quota_sum = '0;
        for (int i = 0; i < srbrm_pkg::NUM_BUFS; i++)
            sh_refs[i] = '0;
        for (int a = 0; a < srbrm_pkg::MAX_CONSUMERS; a++)
        begin
            sh_live[a] = 1'b0;
            sh_next[a] = '0;
            sh_owned[a] = '0;
            sh_quota[a] = '0;
            sh_owns[a] = '0;
            sh_dadd[a] = '0;
            sh_drem[a] = '0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part: corner values and ways in which a request is ignored or refused.
        issue(srbrm_pkg::REQ_END, 5'd3, '0, 1'b0, 3'd0, '0, '0);       // nothing outstanding
        issue(srbrm_pkg::REQ_RETURN, 5'd1, '0, 1'b0, 3'd2, '0, '0);    // slot not live
        issue(srbrm_pkg::REQ_CONSUMED, '0, '0, 1'b0, 3'd2, '0, '1);    // slot not live
        issue(srbrm_pkg::REQ_DETACH, '0, '0, 1'b0, 3'd4, '0, '0);      // slot not live
        issue(srbrm_pkg::REQ_ATTACH, '0, '0, 1'b0, 3'd0, 6'd0, '0);    // zero quota
        issue(srbrm_pkg::REQ_ATTACH, '0, '0, 1'b0, 3'd7, 6'd63, '0);   // largest quota
        issue(srbrm_pkg::REQ_ATTACH, '1, '1, 1'b1, 3'd7, 6'd5, '1);    // already live
        issue(srbrm_pkg::REQ_ATTACH, '0, '0, 1'b0, 3'd3, 6'd32, '0);
        issue(srbrm_pkg::REQ_START, 5'd0, 32'h0000_0000, 1'b0, '0, '0, '0);
        issue(srbrm_pkg::REQ_START, 5'd31, 32'hFFFF_FFFF, 1'b1, '1, '1, '1);
        issue(srbrm_pkg::REQ_RETURN, 5'd31, '0, 1'b0, 3'd7, '0, '0);
        issue(srbrm_pkg::REQ_RETURN, 5'd5, '0, 1'b0, 3'd7, '0, '0);    // not owned
        issue(srbrm_pkg::REQ_CONSUMED, '0, '0, 1'b0, 3'd7, '0, 32'hFFFF_FFFF);
        // Consumer 7 still has ring space here.
        issue(srbrm_pkg::REQ_START, 5'd9, 32'h8000_0000, 1'b1, '0, '0, '0);
        issue(srbrm_pkg::REQ_CONSUMED, '0, '0, 1'b0, 3'd7, '0, sh_dadd[7]);
        issue(srbrm_pkg::REQ_END, 5'd0, '0, 1'b0, '0, '0, '0);
        issue(srbrm_pkg::REQ_END, 5'd9, '0, 1'b0, '0, '0, '0);         // id differs from ring
        issue(srbrm_pkg::REQ_DETACH, '0, '0, 1'b0, 3'd3, '0, '0);
        issue(srbrm_pkg::REQ_DETACH, '0, '0, 1'b0, 3'd7, '0, '0);
        issue(srbrm_pkg::REQ_DETACH, '0, '0, 1'b0, 3'd0, '0, '0);
        // Fill the buffer ring until starts are refused.
        for (int i = 0; i < 34; i++)
            issue(srbrm_pkg::REQ_START, $urandom, $urandom, $urandom, '0, '0, '0);
        drain();

        // Random part in three phases of back-pressure, the last with none. The sender pauses at
        // each boundary until the block has caught up.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 30 : 0;
            for (int a = 0; a < 4; a++)
                issue(srbrm_pkg::REQ_ATTACH, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(1, 6), $urandom);
            if (phase == 0)
                hold_go = 1'b1;
            for (int i = 0; i < 130; i++)
            begin
                issue_random();
                while (pending_reqs.size() > 8)
                    @(posedge clk);
            end
            drain();
        end

        if (mismatches == 0 && owed_results.size() == 0)
            $display("shared_rx_buffer_refcount_manager verification clean");
        else
            $display("shared_rx_buffer_refcount_manager verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/srbrm_pkg.sv
design/srbrm_ring_mem.sv
design/srbrm_ctrl.sv
design/shared_rx_buffer_refcount_manager.sv
bench/tb.sv
